@@ design/msrc_pkg.sv @@
package msrc_pkg;

  typedef logic signed [14:0] speed_t;
  typedef logic [6:0]         pct_t;
  typedef logic [9:0]         ms_t;

  // One tick after the input register: conditioned target, time and stop flag.
  typedef struct packed {
    speed_t target;
    ms_t    elapsed;
    logic   stop;
  } tick_t;

  localparam speed_t FWD_SHUTOFF = 15'sd1500;
  localparam speed_t BWD_SHUTOFF = 15'sd1000;
  localparam speed_t STEP_UP     = 15'sd50;
  localparam speed_t FAST_ABOVE  = 15'sd5000;

  localparam ms_t ELAPSED_MAX = 10'd1000;
  localparam ms_t LED_IDLE    = 10'd1000;
  localparam ms_t LED_STOP    = 10'd200;
  localparam int  LED_MIN     = 20;
  localparam int  LED_SPAN    = 160;

  localparam pct_t PCT_FULL = 7'd100;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 43699.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_MAX_FWD = 1'b0;
  localparam logic REG_MAX_BWD = 1'b1;

  localparam pct_t MAX_FWD_RESET = 7'd60;
  localparam pct_t MAX_BWD_RESET = 7'd35;

endpackage

@@ design/msrc_in_if.sv @@
interface msrc_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] forward_pedal;
  logic [6:0] backward_pedal;
  logic [9:0] elapsed_ms;
  logic       stop_request;

  modport source (output valid, forward_pedal, backward_pedal, elapsed_ms, stop_request,
                  input ready);
  modport sink   (input valid, forward_pedal, backward_pedal, elapsed_ms, stop_request,
                  output ready);
endinterface

@@ design/msrc_out_if.sv @@
interface msrc_out_if #(
  parameter int DUTY_BITS = 10
);
  logic                        valid;
  logic                        ready;
  logic signed [14:0]          speed_now;
  logic        [DUTY_BITS-1:0] fwd_pwm;
  logic        [DUTY_BITS-1:0] bwd_pwm;
  logic        [9:0]           led_half_period;

  modport source (output valid, speed_now, fwd_pwm, bwd_pwm, led_half_period,
                  input ready);
  modport sink   (input valid, speed_now, fwd_pwm, bwd_pwm, led_half_period,
                  output ready);
endinterface

@@ design/msrc_target.sv @@
module msrc_target import msrc_pkg::*; (
  input  pct_t  max_fwd,
  input  pct_t  max_bwd,
  input  pct_t  fwd_pedal,
  input  pct_t  bwd_pedal,
  input  ms_t   elapsed_ms,
  input  logic  stop_request,
  output tick_t tick
);

  logic        fwd_only;
  logic        bwd_only;
  pct_t        limit;
  pct_t        pedal;
  logic [13:0] prod;
  logic [26:0] scaled;
  logic [7:0]  quot;
  logic [7:0]  mag;
  logic [13:0] tgt_mag;
  speed_t      tgt_pos;

  assign fwd_only = (fwd_pedal != '0) && (bwd_pedal == '0);
  assign bwd_only = (bwd_pedal != '0) && (fwd_pedal == '0);
  assign limit    = fwd_only ? max_fwd : max_bwd;
  assign pedal    = fwd_only ? fwd_pedal : bwd_pedal;

  assign prod   = 14'(limit) * 14'(pedal);
  assign scaled = 27'(prod) * 27'(DIV100_MUL);
  assign quot   = scaled[26:DIV100_SHIFT];

  always_comb begin
    mag = quot;
    if (mag > {1'b0, limit}) begin
      mag = {1'b0, limit};
    end
    if (mag > {1'b0, PCT_FULL}) begin
      mag = {1'b0, PCT_FULL};
    end
  end

  assign tgt_mag = 14'(mag[6:0]) * 14'd100;
  assign tgt_pos = speed_t'({1'b0, tgt_mag});

  always_comb begin
    if (fwd_only) begin
      tick.target = tgt_pos;
    end else if (bwd_only) begin
      tick.target = -tgt_pos;
    end else begin
      tick.target = '0;
    end
    tick.elapsed = (elapsed_ms > ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ms;
    tick.stop    = stop_request;
  end

endmodule

@@ design/msrc_step.sv @@
module msrc_step import msrc_pkg::*; (
  input  tick_t  tick,
  input  speed_t cur,
  output speed_t next
);

  logic signed [15:0] cur_w;
  logic signed [15:0] tgt_w;
  logic signed [15:0] brake_w;
  logic signed [15:0] n;
  logic        [14:0] mag;
  logic        [12:0] brake;
  logic               fast;

  assign cur_w = 16'(cur);
  assign tgt_w = 16'(tick.target);
  assign mag   = cur[14] ? 15'(-cur) : 15'(cur);
  assign fast  = mag > 15'(FAST_ABOVE);
  // Braking step is elapsed times 8 or 4 hundredths of a percent.
  assign brake   = fast ? {tick.elapsed, 3'b000} : {1'b0, tick.elapsed, 2'b00};
  assign brake_w = signed'({3'b000, brake});

  always_comb begin
    n = cur_w;
    if (tick.stop) begin
      n = '0;
    end else if (cur_w < tgt_w) begin
      if (cur < 0 && cur > -BWD_SHUTOFF) begin
        n = '0;
      end else if (cur > 0 && cur < FWD_SHUTOFF) begin
        n = 16'(FWD_SHUTOFF);
      end else if (cur < 0) begin
        n = cur_w + brake_w;
      end else begin
        n = cur_w + 16'(STEP_UP);
      end
      if (n > tgt_w) begin
        n = tgt_w;
      end
    end else if (cur_w > tgt_w) begin
      if (cur > 0 && cur < FWD_SHUTOFF) begin
        n = '0;
      end else if (cur < 0 && cur > -BWD_SHUTOFF) begin
        n = -16'(BWD_SHUTOFF);
      end else if (cur > 0) begin
        n = cur_w - brake_w;
      end else begin
        n = cur_w - 16'(STEP_UP);
      end
      if (n < tgt_w) begin
        n = tgt_w;
      end
    end
  end

  // Except on a stop, the clamp keeps the result between the old speed and the target.
  assign next = speed_t'(n[14:0]);

endmodule

@@ design/msrc_format.sv @@
module msrc_format import msrc_pkg::*; #(
  parameter int DUTY_BITS = 10
) (
  input  speed_t               speed,
  input  logic                 stop,
  output logic [DUTY_BITS-1:0] fwd_duty,
  output logic [DUTY_BITS-1:0] bwd_duty,
  output ms_t                  led
);

  localparam int MAXD = (1 << DUTY_BITS) - 1;

  logic [DUTY_BITS-1:0] duty_rom [128];
  ms_t                  led_rom  [128];
  logic                 neg;
  logic [14:0]          abs_speed;
  logic [27:0]          scaled;
  pct_t                 pct;

  // Constant tables indexed by whole percent; entries above 100 are never read.
  for (genvar gi = 0; gi < 128; gi++) begin : g_rom
    assign duty_rom[gi] = DUTY_BITS'((gi * MAXD + 50) / 100);
    assign led_rom[gi]  = 10'(LED_MIN + ((100 - gi) * LED_SPAN) / 100);
  end

  assign neg       = speed[14];
  assign abs_speed = neg ? 15'(-speed) : 15'(speed);
  assign scaled    = 28'(abs_speed) * 28'(DIV100_MUL);
  assign pct       = scaled[DIV100_SHIFT+6:DIV100_SHIFT];

  assign fwd_duty = (!neg && pct != '0) ? duty_rom[pct] : '0;
  assign bwd_duty = (neg && pct != '0) ? duty_rom[pct] : '0;

  always_comb begin
    if (stop) begin
      led = LED_STOP;
    end else if (pct == '0) begin
      led = LED_IDLE;
    end else begin
      led = led_rom[pct];
    end
  end

endmodule

@@ design/motor_speed_ramp_controller_core.sv @@
// Motor speed ramp controller.
// Input channel in_ch carries one control tick per word: both pedal positions,
// elapsed milliseconds and a stop request. Output channel out_ch returns one word
// per tick: the new signed speed in hundredths of a percent, the forward and
// backward PWM duties and the status LED half period.
// The two speed limits are set over the APB port (forward at 0x0, backward at
// 0x4) and read back there; they should only change while no tick is in flight.
// The block is a three-stage pipeline: input register with the target computed,
// speed update into the speed register, then duty and LED into the output
// register. An accepted tick passes the input, speed and output registers in
// that order before out_ch.valid rises; one tick is taken every cycle while the
// output is not stalled, and the speed feedback closes within the middle stage.
// All stages move together, so when the receiver holds out_ch.ready low with a
// word waiting, in_ch.ready drops and everything holds in place.
// Reset clears the pipeline, sets the speed to zero and loads the limits with
// 60 and 35 percent.
module motor_speed_ramp_controller_core import msrc_pkg::*; #(
  parameter int DUTY_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  msrc_in_if.sink     in_ch,
  msrc_out_if.source  out_ch
);

  pct_t                 max_fwd;
  pct_t                 max_bwd;
  logic                 advance;
  tick_t                tick_in;
  tick_t                s1_tick;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 s2_stop;
  speed_t               speed_store;
  speed_t               speed_next;
  logic [DUTY_BITS-1:0] fwd_duty;
  logic [DUTY_BITS-1:0] bwd_duty;
  ms_t                  led;
  logic                 out_valid;
  speed_t               out_speed;
  logic [DUTY_BITS-1:0] out_fwd;
  logic [DUTY_BITS-1:0] out_bwd;
  ms_t                  out_led;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fwd <= MAX_FWD_RESET;
      max_bwd <= MAX_BWD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MAX_FWD: max_fwd <= pwdata[6:0];
        REG_MAX_BWD: max_bwd <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_FWD: prdata = {25'd0, max_fwd};
      REG_MAX_BWD: prdata = {25'd0, max_bwd};
      default:     prdata = '0;
    endcase
  end

  msrc_target u_target (
    .max_fwd      (max_fwd),
    .max_bwd      (max_bwd),
    .fwd_pedal    (in_ch.forward_pedal),
    .bwd_pedal    (in_ch.backward_pedal),
    .elapsed_ms   (in_ch.elapsed_ms),
    .stop_request (in_ch.stop_request),
    .tick         (tick_in)
  );

  msrc_step u_step (
    .tick (s1_tick),
    .cur  (speed_store),
    .next (speed_next)
  );

  // While the middle stage is valid, speed_store holds that word's speed.
  msrc_format #(
    .DUTY_BITS (DUTY_BITS)
  ) u_format (
    .speed    (speed_store),
    .stop     (s2_stop),
    .fwd_duty (fwd_duty),
    .bwd_duty (bwd_duty),
    .led      (led)
  );

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      speed_store <= '0;
    end else if (advance) begin
      s1_valid  <= in_ch.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s1_valid) begin
        speed_store <= speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_ch.valid) begin
        s1_tick <= tick_in;
      end
      if (s1_valid) begin
        s2_stop <= s1_tick.stop;
      end
      if (s2_valid) begin
        out_speed <= speed_store;
        out_fwd   <= fwd_duty;
        out_bwd   <= bwd_duty;
        out_led   <= led;
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.speed_now       = out_speed;
  assign out_ch.fwd_pwm         = out_fwd;
  assign out_ch.bwd_pwm         = out_bwd;
  assign out_ch.led_half_period = out_led;

endmodule

@@ design/msrc_checker.sv @@
module msrc_checker import msrc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input speed_t speed_now,
  input logic   fwd_active,
  input logic   bwd_active,
  input ms_t    led
);

  // A waiting word stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed_now))
    else $error("output word changed while stalled");

  // The whole pipeline stalls with the output, so no new tick is taken.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_now >= -15'sd10000 && speed_now <= 15'sd10000)
    else $error("speed out of range");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fwd_active && bwd_active))
    else $error("both duties active");

  a_idle_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_now == '0 |-> led == LED_IDLE || led == LED_STOP)
    else $error("LED period wrong at standstill");

endmodule

bind motor_speed_ramp_controller_core msrc_checker u_msrc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .speed_now  (out_ch.speed_now),
  .fwd_active (|out_ch.fwd_pwm),
  .bwd_active (|out_ch.bwd_pwm),
  .led        (out_ch.led_half_period)
);
